[rtl/numeric_literal_scanner_defines.svh]
// Assertion macros used by the numeric literal scanner core.
`ifndef NUMERIC_LITERAL_SCANNER_DEFINES_SVH
`define NUMERIC_LITERAL_SCANNER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/nls_pkg.sv]
// Shared widths, codes and the result type of the numeric literal scanner.
package nls_pkg;

    localparam int CHAR_W                  = 8;
    localparam int VALUE_W                 = 64;
    localparam int KIND_W                  = 2;
    localparam int TEXT_LEN_W              = 8;
    localparam int DEFAULT_MAX_TEXT_LENGTH = 255;

    localparam logic [KIND_W-1:0] KIND_INT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LONG   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FLOAT  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]     literal_kind;
        logic                  unsigned_mark;
        logic [VALUE_W-1:0]    integer_value;
        logic                  handed_back;
        logic [TEXT_LEN_W-1:0] text_length;
        logic                  length_overflow;
    } nls_result_t;

endpackage

[rtl/numeric_literal_scanner.sv]
// A literal's result is registered and appears on m_axis in the cycle after the closing transaction.
// Throughput: one character per cycle while the input is not stalled; the scan state updates in the accepting cycle.
// The result register lets a character enter while the previous result is being taken.
// Input stalls only while a held result is not taken by the downstream side.
// Reset (rst_n low, asynchronous) returns the scanner to idle and drops any held result.
module numeric_literal_scanner #(
    parameter int MAX_TEXT_LENGTH = nls_pkg::DEFAULT_MAX_TEXT_LENGTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic [1:0]  s_axis_tuser,   // [0] starts_literal, [1] end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] integer_value, [71:64] text_length
    output logic [4:0]  m_axis_tuser    // [1:0] literal_kind, [2] unsigned_mark,
                                        // [3] handed_back, [4] length_overflow
);

    logic                 accept;
    logic                 emit;
    nls_pkg::nls_result_t core_result;
    nls_pkg::nls_result_t out_result;

    assign accept = s_axis_tvalid && s_axis_tready;

    nls_core #(
        .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .char_code      (s_axis_tdata),
        .starts_literal (s_axis_tuser[0]),
        .end_of_text    (s_axis_tuser[1]),
        .emit           (emit),
        .result         (core_result)
    );

    nls_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .load_data (core_result),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = {out_result.text_length, out_result.integer_value};
    assign m_axis_tuser = {out_result.length_overflow, out_result.handed_back,
                           out_result.unsigned_mark, out_result.literal_kind};

endmodule

[rtl/nls_core.sv]
// Literal scanning state and the per-character next-state and result logic.
`include "numeric_literal_scanner_defines.svh"

module nls_core #(
    parameter int MAX_TEXT_LENGTH = nls_pkg::DEFAULT_MAX_TEXT_LENGTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [nls_pkg::CHAR_W-1:0]  char_code,
    input  logic                        starts_literal,
    input  logic                        end_of_text,
    output logic                        emit,
    output nls_pkg::nls_result_t        result
);

    localparam int CNT_W = $clog2(MAX_TEXT_LENGTH + 1);
    localparam int EXT_W = CNT_W + nls_pkg::TEXT_LEN_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT_LENGTH);

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_ZERO   = 4'd1;
    localparam logic [3:0] PH_DEC    = 4'd2;
    localparam logic [3:0] PH_HEX    = 4'd3;
    localparam logic [3:0] PH_DFRAC  = 4'd4;
    localparam logic [3:0] PH_HFRAC  = 4'd5;
    localparam logic [3:0] PH_EXPM   = 4'd6;
    localparam logic [3:0] PH_EXPS   = 4'd7;
    localparam logic [3:0] PH_EXPD   = 4'd8;
    localparam logic [3:0] PH_FDONED = 4'd9;
    localparam logic [3:0] PH_FDONEF = 4'd10;
    localparam logic [3:0] PH_SU     = 4'd11;
    localparam logic [3:0] PH_SL     = 4'd12;
    localparam logic [3:0] PH_SLL    = 4'd13;
    localparam logic [3:0] PH_SDONE  = 4'd14;

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_L   = 8'h6C;
    localparam logic [7:0] CH_LC_P   = 8'h70;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    logic [3:0]                  phase_reg, phase_next;
    logic [nls_pkg::VALUE_W-1:0] value_reg, value_next;
    logic                        oct_base_reg, oct_base_next;
    logic                        oct_valid_reg, oct_valid_next;
    logic                        uns_reg, uns_next;
    logic                        long_reg, long_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        ovf_reg, ovf_next;

    // Character classes; letters are folded to lower case.
    logic [7:0] lc;
    logic       is_digit, is_hex_alpha, is_hex, is_dot, is_sign;
    logic       is_e, is_p, is_x, is_u, is_l, is_f;
    logic [3:0] digit_val, hex_val;

    assign lc           = char_code | CASE_BIT;
    assign is_digit     = (char_code >= CH_0) && (char_code <= CH_9);
    assign is_hex_alpha = (lc >= CH_LC_A) && (lc <= CH_LC_F);
    assign is_hex       = is_digit || is_hex_alpha;
    assign is_dot       = (char_code == CH_DOT);
    assign is_sign      = (char_code == CH_PLUS) || (char_code == CH_MINUS);
    assign is_e         = (lc == CH_LC_E);
    assign is_p         = (lc == CH_LC_P);
    assign is_x         = (lc == CH_LC_X);
    assign is_u         = (lc == CH_LC_U);
    assign is_l         = (lc == CH_LC_L);
    assign is_f         = (lc == CH_LC_F);
    assign digit_val    = 4'(char_code - CH_0);
    assign hex_val      = is_digit ? digit_val : 4'(lc - CH_LC_A + 8'd10);

    // Shift-add products of the running value.
    logic [nls_pkg::VALUE_W-1:0] mul8, mul10, mul16;
    assign mul8  = {value_reg[nls_pkg::VALUE_W-4:0], 3'b000};
    assign mul10 = mul8 + {value_reg[nls_pkg::VALUE_W-2:0], 1'b0};
    assign mul16 = {value_reg[nls_pkg::VALUE_W-5:0], 4'b0000};

    // Integer suffix acceptance, per phase.
    logic       sfx_ok, sfx_u, sfx_l;
    logic [3:0] sfx_phase;

    always_comb
    begin
        sfx_ok    = 1'b0;
        sfx_u     = 1'b0;
        sfx_l     = 1'b0;
        sfx_phase = phase_reg;
        unique case (phase_reg)
            PH_ZERO, PH_DEC, PH_HEX:
            begin
                if (is_u)
                begin
                    sfx_ok = 1'b1; sfx_u = 1'b1; sfx_phase = PH_SU;
                end
                else if (is_l)
                begin
                    sfx_ok = 1'b1; sfx_l = 1'b1; sfx_phase = PH_SL;
                end
            end
            PH_SU:
            begin
                if (is_l)
                begin
                    sfx_ok = 1'b1; sfx_l = 1'b1; sfx_phase = PH_SL;
                end
            end
            PH_SL:
            begin
                if (is_l)
                begin
                    sfx_ok = 1'b1; sfx_phase = PH_SLL;
                end
                else if (is_u && !uns_reg)
                begin
                    sfx_ok = 1'b1; sfx_u = 1'b1; sfx_phase = PH_SDONE;
                end
            end
            PH_SLL:
            begin
                if (is_u && !uns_reg)
                begin
                    sfx_ok = 1'b1; sfx_u = 1'b1; sfx_phase = PH_SDONE;
                end
            end
            default:
            begin
                sfx_ok = 1'b0;
            end
        endcase
    end

    // Float suffix acceptance.
    logic       fsfx_ok;
    logic [3:0] fsfx_phase;
    assign fsfx_ok    = is_f || is_l;
    assign fsfx_phase = is_f ? PH_FDONEF : PH_FDONED;

    // Decimal or octal digit accumulation; a leading zero switches to octal.
    logic                        oct_eff, oct_valid_dig;
    logic [nls_pkg::VALUE_W-1:0] dig_value;
    assign oct_eff       = oct_base_reg || (phase_reg == PH_ZERO);
    assign oct_valid_dig = oct_valid_reg && (digit_val <= 4'd7);

    always_comb
    begin
        if (!oct_eff)
            dig_value = mul10 + nls_pkg::VALUE_W'(digit_val);
        else if (oct_valid_dig)
            dig_value = mul8 + nls_pkg::VALUE_W'(digit_val);
        else
            dig_value = value_reg;
    end

    // Next state for one transaction.
    logic fit, take, hand_back;

    always_comb
    begin
        phase_next     = phase_reg;
        value_next     = value_reg;
        oct_base_next  = oct_base_reg;
        oct_valid_next = oct_valid_reg;
        uns_next       = uns_reg;
        long_next      = long_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        emit           = 1'b0;
        hand_back      = 1'b0;
        fit            = 1'b1;
        take           = 1'b0;

        if (accept)
        begin
            if (end_of_text || starts_literal)
            begin
                emit           = (phase_reg != PH_IDLE);
                hand_back      = !end_of_text;
                phase_next     = PH_IDLE;
                value_next     = '0;
                oct_base_next  = 1'b0;
                oct_valid_next = 1'b1;
                uns_next       = 1'b0;
                long_next      = 1'b0;
                count_next     = '0;
                ovf_next       = 1'b0;
                // A start on a character that cannot open a literal stays idle.
                if (!end_of_text && (is_digit || is_dot))
                begin
                    count_next = CNT_W'(1);
                    if (is_dot)
                        phase_next = PH_DFRAC;
                    else if (char_code == CH_0)
                        phase_next = PH_ZERO;
                    else
                    begin
                        phase_next = PH_DEC;
                        value_next = nls_pkg::VALUE_W'(digit_val);
                    end
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                unique case (phase_reg)
                    PH_ZERO, PH_DEC:
                    begin
                        if ((phase_reg == PH_ZERO) && is_x)
                        begin
                            take = 1'b1; phase_next = PH_HEX;
                        end
                        else if (is_digit)
                        begin
                            take           = 1'b1;
                            phase_next     = PH_DEC;
                            oct_base_next  = oct_eff;
                            oct_valid_next = oct_eff ? oct_valid_dig : oct_valid_reg;
                            value_next     = dig_value;
                        end
                        else if (is_dot)
                        begin
                            take = 1'b1; phase_next = PH_DFRAC;
                        end
                        else if (is_e)
                        begin
                            take = 1'b1; phase_next = PH_EXPM;
                        end
                        else
                            fit = sfx_ok;
                    end
                    PH_HEX:
                    begin
                        if (is_hex)
                        begin
                            take       = 1'b1;
                            value_next = mul16 + nls_pkg::VALUE_W'(hex_val);
                        end
                        else if (is_dot)
                        begin
                            take = 1'b1; phase_next = PH_HFRAC;
                        end
                        else if (is_p)
                        begin
                            take = 1'b1; phase_next = PH_EXPM;
                        end
                        else
                            fit = sfx_ok;
                    end
                    PH_DFRAC:
                    begin
                        if (is_digit)
                            take = 1'b1;
                        else if (is_e)
                        begin
                            take = 1'b1; phase_next = PH_EXPM;
                        end
                        else
                            fit = fsfx_ok;
                    end
                    PH_HFRAC:
                    begin
                        if (is_hex)
                            take = 1'b1;
                        else if (is_p)
                        begin
                            take = 1'b1; phase_next = PH_EXPM;
                        end
                        else
                            fit = fsfx_ok;
                    end
                    PH_EXPM:
                    begin
                        if (is_sign)
                        begin
                            take = 1'b1; phase_next = PH_EXPS;
                        end
                        else if (is_digit)
                        begin
                            take = 1'b1; phase_next = PH_EXPD;
                        end
                        else
                            fit = fsfx_ok;
                    end
                    PH_EXPS, PH_EXPD:
                    begin
                        if (is_digit)
                        begin
                            take = 1'b1; phase_next = PH_EXPD;
                        end
                        else
                            fit = fsfx_ok;
                    end
                    PH_SU, PH_SL, PH_SLL:
                    begin
                        fit = sfx_ok;
                    end
                    default:
                    begin
                        fit = 1'b0;
                    end
                endcase

                if (fit && !take)
                begin
                    // Suffix character: the phase tells which suffix table applies.
                    if (phase_reg == PH_DFRAC || phase_reg == PH_HFRAC
                        || phase_reg == PH_EXPM || phase_reg == PH_EXPS
                        || phase_reg == PH_EXPD)
                        phase_next = fsfx_phase;
                    else
                    begin
                        phase_next = sfx_phase;
                        uns_next   = uns_reg || sfx_u;
                        long_next  = long_reg || sfx_l;
                    end
                end

                if (take)
                begin
                    if (count_reg != CNT_MAX)
                        count_next = count_reg + CNT_W'(1);
                    else
                        ovf_next = 1'b1;
                end

                if (!fit)
                begin
                    emit           = 1'b1;
                    hand_back      = 1'b1;
                    phase_next     = PH_IDLE;
                    value_next     = '0;
                    oct_base_next  = 1'b0;
                    oct_valid_next = 1'b1;
                    uns_next       = 1'b0;
                    long_next      = 1'b0;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                end
            end
        end
    end

    // The emitted literal is the state before this transaction, handed_back aside.
    logic             float_lit;
    logic [EXT_W-1:0] count_ext;
    assign float_lit = (phase_reg >= PH_DFRAC) && (phase_reg <= PH_FDONEF);
    assign count_ext = EXT_W'(count_reg);

    always_comb
    begin
        if (phase_reg == PH_FDONEF)
            result.literal_kind = nls_pkg::KIND_FLOAT;
        else if (float_lit)
            result.literal_kind = nls_pkg::KIND_DOUBLE;
        else if (long_reg)
            result.literal_kind = nls_pkg::KIND_LONG;
        else
            result.literal_kind = nls_pkg::KIND_INT;
        result.unsigned_mark   = !float_lit && uns_reg;
        result.integer_value   = float_lit ? '0 : value_reg;
        result.handed_back     = hand_back;
        result.text_length     = (count_ext > EXT_W'(8'hFF)) ? 8'hFF
                                 : count_ext[nls_pkg::TEXT_LEN_W-1:0];
        result.length_overflow = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            value_reg     <= '0;
            oct_base_reg  <= 1'b0;
            oct_valid_reg <= 1'b1;
            uns_reg       <= 1'b0;
            long_reg      <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            value_reg     <= value_next;
            oct_base_reg  <= oct_base_next;
            oct_valid_reg <= oct_valid_next;
            uns_reg       <= uns_next;
            long_reg      <= long_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
        end
    end

    `NLS_ASSERT_NEXT(a_eot_goes_idle, accept && end_of_text, phase_reg == PH_IDLE,
        "scanner not idle after end of text")
    `NLS_ASSERT_NOW(a_ovf_at_max, ovf_reg, count_reg == CNT_MAX,
        "length overflow flagged below the maximum length")
    `NLS_ASSERT_NOW(a_idle_is_clear, phase_reg == PH_IDLE,
        (value_reg == '0) && (count_reg == '0) && !ovf_reg && !uns_reg && !long_reg,
        "idle scanner holds literal state")
    `NLS_ASSERT_NOW(a_no_emit_idle, emit, accept && (phase_reg != PH_IDLE),
        "result raised without an open literal")

endmodule

[rtl/nls_out_reg.sv]
// Result register that decouples the result stream from character input.
module nls_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  nls_pkg::nls_result_t load_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 in_ready,
    output nls_pkg::nls_result_t out_data
);

    logic                 valid_reg;
    nls_pkg::nls_result_t data_reg;

    // A new character may enter whenever no result is held or the held result leaves this cycle.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

endmodule
